// ----- src/bounded_edit_distance_top_defines.svh -----
// Assertion macros used by the bounded edit distance RTL.
`ifndef BOUNDED_EDIT_DISTANCE_TOP_DEFINES_SVH
`define BOUNDED_EDIT_DISTANCE_TOP_DEFINES_SVH

// Check an implication in the same cycle.
`define BED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle.
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bed_pkg.sv -----
// Shared constants, types and codes for the bounded edit distance block.
`timescale 1ns / 1ps
package bed_pkg;

  localparam int MAX_LEN = 128;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SYM_W   = 8;
  localparam int DIST_W  = 8;
  localparam int OP_W    = 2;
  localparam int COST_W  = LEN_W;

  localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPARE       = 2'd2;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [SYM_W-1:0]  sym_t;

  // Operands of one dynamic-programming cell.
  typedef struct packed {
    cost_t up;
    cost_t diag;
    cost_t left;
    sym_t  sym_a;
    sym_t  sym_b;
  } cell_in_t;

endpackage

// ----- src/bed_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register one read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bed_cell.sv -----
// Shared cost unit: one Levenshtein cell, min of substitute, delete, insert.
`timescale 1ns / 1ps
module bed_cell (
  input  bed_pkg::cell_in_t cell_in,
  output bed_pkg::cost_t    cell_cost
);
  import bed_pkg::*;

  logic [COST_W:0] sub_cost;
  logic [COST_W:0] del_cost;
  logic [COST_W:0] ins_cost;
  logic [COST_W:0] min_ab;
  logic [COST_W:0] min_all;

  // Form the three candidate costs one bit wider.
  always_comb begin
    sub_cost = {1'b0, cell_in.diag} +
               ((cell_in.sym_a != cell_in.sym_b) ? (COST_W+1)'(1) : (COST_W+1)'(0));
    del_cost = {1'b0, cell_in.up} + (COST_W+1)'(1);
    ins_cost = {1'b0, cell_in.left} + (COST_W+1)'(1);
    min_ab   = (sub_cost < del_cost) ? sub_cost : del_cost;
    min_all  = (min_ab < ins_cost) ? min_ab : ins_cost;
  end

  // A cell never exceeds the longest string, so drop the guard bit.
  assign cell_cost = min_all[COST_W-1:0];

endmodule

// ----- src/bounded_edit_distance_top.sv -----
// Top level of the bounded edit distance engine: loader, sequencer, output register.
//
// Input channel (in_valid / in_stall, in_operation, in_symbol): operation 0
// appends in_symbol to the first string, 1 to the second, 2 compares and
// clears both strings, 3 does nothing. A transfer happens when in_valid is
// high and in_stall is low. A load gives no result.
// Symbols past 128 per string are dropped and reported as truncated.
// A compare gives one result on the out_ channel (out_valid / out_stall):
// out_distance, out_over_limit, out_truncated. The sweep fetches each row,
// then works its cells with the single cost cell and the cost-row memory
// port, one cell a cycle; when either string is empty it goes straight to
// the result.
// in_stall stays high while a compare runs. A result waits in the output
// register while out_stall is high; loads are still taken meanwhile, and a
// following compare holds its result until the register frees.
// cfg_valid / cfg_ready / cfg_data writes distance_limit (reset value 99);
// cfg_ready is high whenever no compare runs. Reset (rst_n low, synchronous)
// empties both strings, clears the truncation flag and drops any result.
`timescale 1ns / 1ps
`include "bounded_edit_distance_top_defines.svh"
module bounded_edit_distance_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [bed_pkg::OP_W-1:0]  in_operation,
  input  logic [bed_pkg::SYM_W-1:0] in_symbol,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [bed_pkg::DIST_W-1:0] out_distance,
  output logic                    out_over_limit,
  output logic                    out_truncated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [bed_pkg::DIST_W-1:0] cfg_data
);
  import bed_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW_READ,
    ST_CELL,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  cnt1_r, cnt1_nxt;
  logic [LEN_W-1:0]  cnt2_r, cnt2_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt;
  logic [LEN_W-1:0]  j_r, j_nxt;
  cost_t             left_r, left_nxt;
  cost_t             diag_r, diag_nxt;
  cost_t             res_r, res_nxt;
  logic [DIST_W-1:0] limit_r, limit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_over_r, out_over_nxt;
  logic              out_trunc_r, out_trunc_nxt;

  logic              in_xfer;
  logic              we1, we2, re1, re2, cost_we, cost_re;
  logic [ADDR_W-1:0] waddr1, waddr2, raddr1, raddr2, cost_waddr, cost_raddr;
  logic [LEN_W-1:0]  i_m1, j_m1;
  sym_t              sym_a, sym_b;
  cost_t             cost_rd;
  cell_in_t          cell_in;
  cost_t             cell_cost;
  logic [DIST_W-1:0] res_dist;
  logic              res_over;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);

  assign i_m1 = i_r - LEN_W'(1);
  assign j_m1 = j_r - LEN_W'(1);

  // Load ports: append at the current fill count.
  assign we1    = in_xfer && (in_operation == OP_APPEND_FIRST) && (cnt1_r < LEN_W'(MAX_LEN));
  assign we2    = in_xfer && (in_operation == OP_APPEND_SECOND) && (cnt2_r < LEN_W'(MAX_LEN));
  assign waddr1 = cnt1_r[ADDR_W-1:0];
  assign waddr2 = cnt2_r[ADDR_W-1:0];

  // Row fetch: first-string symbol once per row, second string and cost row per cell.
  assign re1        = (state_r == ST_ROW_READ);
  assign raddr1     = i_m1[ADDR_W-1:0];
  assign re2        = (state_r == ST_ROW_READ) || ((state_r == ST_CELL) && (j_r != cnt2_r));
  assign raddr2     = (state_r == ST_ROW_READ) ? '0 : j_r[ADDR_W-1:0];
  assign cost_re    = re2;
  assign cost_raddr = raddr2;
  assign cost_we    = (state_r == ST_CELL);
  assign cost_waddr = j_m1[ADDR_W-1:0];

  bed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first_text (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (in_symbol),
    .re    (re1),
    .raddr (raddr1),
    .rdata (sym_a)
  );

  bed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second_text (
    .clk   (clk),
    .we    (we2),
    .waddr (waddr2),
    .wdata (in_symbol),
    .re    (re2),
    .raddr (raddr2),
    .rdata (sym_b)
  );

  bed_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN)) u_cost_row (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (cell_cost),
    .re    (cost_re),
    .raddr (cost_raddr),
    .rdata (cost_rd)
  );

  // Feed the cost cell; the first row's upper neighbor is the column index.
  always_comb begin
    cell_in.up    = (i_r == LEN_W'(1)) ? j_r : cost_rd;
    cell_in.diag  = diag_r;
    cell_in.left  = left_r;
    cell_in.sym_a = sym_a;
    cell_in.sym_b = sym_b;
  end

  bed_cell u_cell (
    .cell_in   (cell_in),
    .cell_cost (cell_cost)
  );

  // Clamp the final distance against the limit.
  assign res_over = DIST_W'(res_r) > limit_r;
  assign res_dist = res_over ? (limit_r + DIST_W'(1)) : DIST_W'(res_r);

  // Sequence loads, the row sweep and the result handoff.
  always_comb begin
    state_nxt     = state_r;
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    res_nxt       = res_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt  = out_dist_r;
    out_over_nxt  = out_over_r;
    out_trunc_nxt = out_trunc_r;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (in_operation == OP_APPEND_FIRST) begin
            if (we1) begin
              cnt1_nxt = cnt1_r + LEN_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (in_operation == OP_APPEND_SECOND) begin
            if (we2) begin
              cnt2_nxt = cnt2_r + LEN_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (in_operation == OP_COMPARE) begin
            if ((cnt1_r == '0) || (cnt2_r == '0)) begin
              res_nxt   = cnt1_r + cnt2_r;
              state_nxt = ST_FINISH;
            end else begin
              i_nxt     = LEN_W'(1);
              state_nxt = ST_ROW_READ;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ROW_READ: begin
        left_nxt  = i_r;
        diag_nxt  = i_m1;
        j_nxt     = LEN_W'(1);
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        left_nxt = cell_cost;
        diag_nxt = cell_in.up;
        if (j_r == cnt2_r) begin
          if (i_r == cnt1_r) begin
            res_nxt   = cell_cost;
            state_nxt = ST_FINISH;
          end else begin
            i_nxt     = i_r + LEN_W'(1);
            state_nxt = ST_ROW_READ;
          end
        end else begin
          j_nxt = j_r + LEN_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist;
          out_over_nxt  = res_over;
          out_trunc_nxt = ovf_r;
          cnt1_nxt      = '0;
          cnt2_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      limit_r     <= DIST_W'(99);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    left_r      <= left_nxt;
    diag_r      <= diag_nxt;
    res_r       <= res_nxt;
    out_dist_r  <= out_dist_nxt;
    out_over_r  <= out_over_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_dist_r;
  assign out_over_limit = out_over_r;
  assign out_truncated  = out_trunc_r;

  // Sweep stays inside the loaded strings.
  `BED_ASSERT_NOW(a_cell_in_range, (state_r == ST_CELL), ((j_r != '0) && (j_r <= cnt2_r) && (i_r != '0) && (i_r <= cnt1_r)), "cell index outside loaded strings")
  // A compare transfer always starts work.
  `BED_ASSERT_NEXT(a_compare_busy, (in_valid && !in_stall && (in_operation == OP_COMPARE)), (state_r != ST_IDLE), "compare did not start")
  // A finished compare lands in the output register once it frees.
  `BED_ASSERT_NEXT(a_finish_out, ((state_r == ST_FINISH) && !(out_valid_r && out_stall)), (out_valid_r && (state_r == ST_IDLE) && (cnt1_r == '0) && (cnt2_r == '0)), "result not delivered")

endmodule

// ----- tb/bounded_edit_distance_top_tb.sv -----
// Self-checking testbench for the bounded edit distance engine.
`timescale 1ns / 1ps
module bounded_edit_distance_top_tb;

  localparam logic [bed_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [bed_pkg::DIST_W-1:0] distance;
    logic                       over_limit;
    logic                       truncated;
  } distance_result_t;

  // Track both strings and the limit; predict one result per compare.
  class distance_scoreboard;
    logic [7:0]       first_text[$];
    logic [7:0]       second_text[$];
    bit               overflow_seen;
    int unsigned      limit;
    distance_result_t pending[$];
    int               errors, loads, compares, over_hits, truncated_hits, checked;

    function new();
      limit = 99;
    endfunction

    function void set_limit(logic [7:0] value);
      limit = value;
    endfunction

    // Full row-at-a-time Levenshtein distance over the kept symbols.
    function int levenshtein();
      int row[bed_pkg::MAX_LEN+1];
      int diag, up, cost, i, j;
      for (j = 0; j <= second_text.size(); j++) row[j] = j;
      for (i = 1; i <= first_text.size(); i++) begin
        diag = row[0];
        row[0] = i;
        for (j = 1; j <= second_text.size(); j++) begin
          up = row[j];
          cost = diag + ((first_text[i-1] == second_text[j-1]) ? 0 : 1);
          if (up + 1 < cost) cost = up + 1;
          if (row[j-1] + 1 < cost) cost = row[j-1] + 1;
          row[j] = cost;
          diag = up;
        end
      end
      return row[second_text.size()];
    endfunction

    function void note_transfer(logic [1:0] op, logic [7:0] sym);
      distance_result_t res;
      int d;
      case (op)
        bed_pkg::OP_APPEND_FIRST: begin
          loads++;
          if (first_text.size() < bed_pkg::MAX_LEN) first_text = {first_text, sym};
          else overflow_seen = 1'b1;
        end
        bed_pkg::OP_APPEND_SECOND: begin
          loads++;
          if (second_text.size() < bed_pkg::MAX_LEN) second_text = {second_text, sym};
          else overflow_seen = 1'b1;
        end
        bed_pkg::OP_COMPARE: begin
          d = levenshtein();
          res.over_limit = (d > limit);
          res.distance   = res.over_limit ? 8'(limit + 1) : 8'(d);
          res.truncated  = overflow_seen;
          pending = {pending, res};
          compares++;
          if (res.over_limit) over_hits++;
          if (res.truncated) truncated_hits++;
          first_text.delete();
          second_text.delete();
          overflow_seen = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] distance, logic over_limit, logic truncated);
      distance_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: out_distance %0d", distance);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (distance !== want.distance) begin
        $error("out_distance: expected %0d, got %0d", want.distance, distance);
        errors++;
      end
      if (over_limit !== want.over_limit) begin
        $error("out_over_limit: expected %0d, got %0d", want.over_limit, over_limit);
        errors++;
      end
      if (truncated !== want.truncated) begin
        $error("out_truncated: expected %0d, got %0d", want.truncated, truncated);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [bed_pkg::OP_W-1:0]    in_operation = '0;
  logic [bed_pkg::SYM_W-1:0]   in_symbol = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [bed_pkg::DIST_W-1:0]  out_distance;
  logic                        out_over_limit;
  logic                        out_truncated;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [bed_pkg::DIST_W-1:0]  cfg_data = '0;

  distance_scoreboard dist_board = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int output_hold = 0;

  bounded_edit_distance_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_distance   (out_distance),
    .out_over_limit (out_over_limit),
    .out_truncated  (out_truncated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run: the slowest correct run stays well under a tenth of this.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Check accepted results, then pick the next stall level.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        dist_board.check_result(out_distance, out_over_limit, out_truncated);
      if (output_hold > 0) begin
        out_stall <= 1'b1;
        output_hold--;
      end else if (receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] pick_symbol(bit narrow);
    return narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255));
  endfunction

  // Offer one item, with optional idle cycles first; hold it until the transfer.
  task automatic send_item(input logic [1:0] op, input logic [7:0] sym);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_symbol    <= sym;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    dist_board.note_transfer(op, sym);
  endtask

  task automatic wait_drained();
    while (dist_board.outstanding() != 0) @(posedge clk);
  endtask

  // Load both strings in a random interleaving, then compare.
  task automatic send_strings(input logic [7:0] a[$], input logic [7:0] b[$], input bit noisy);
    int ia, ib;
    ia = 0;
    ib = 0;
    while (ia < a.size() || ib < b.size()) begin
      if (noisy && $urandom_range(7) == 0) send_item(OP_UNUSED, 8'($urandom));
      if (ib >= b.size() || (ia < a.size() && $urandom_range(1))) begin
        send_item(bed_pkg::OP_APPEND_FIRST, a[ia]);
        ia++;
      end else begin
        send_item(bed_pkg::OP_APPEND_SECOND, b[ib]);
        ib++;
      end
    end
    send_item(bed_pkg::OP_COMPARE, 8'($urandom));
  endtask

  // Write the limit once the engine is idle.
  task automatic write_limit(input logic [7:0] value);
    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    dist_board.set_limit(value);
  endtask

  // Mostly load/compare sequences, some close variants, some noise.
  task automatic run_phase(input int items, input int send_pct, input int recv_pct);
    logic [7:0] a[$];
    logic [7:0] b[$];
    int done, roll, n, k, pos;
    bit narrow;
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    done = 0;
    while (done < items) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        // stray operation of any kind, compares of leftovers included
        k = $urandom_range(3);
        send_item(2'(k), 8'($urandom));
        if (2'(k) != OP_UNUSED) done++;
      end else begin
        narrow = $urandom_range(1);
        a.delete();
        b.delete();
        n = $urandom_range(8);
        repeat (n) a = {a, pick_symbol(narrow)};
        if (roll < 50) begin
          n = $urandom_range(8);
          repeat (n) b = {b, pick_symbol(narrow)};
        end else begin
          // edit a copy so distances land around small limits
          b = a;
          k = $urandom_range(4);
          repeat (k) begin
            pos = $urandom_range(b.size());
            case ($urandom_range(2))
              0: b.insert(pos, pick_symbol(narrow));
              1: if (pos < b.size()) b.delete(pos);
              default: if (pos < b.size()) b[pos] = pick_symbol(narrow);
            endcase
          end
        end
        send_strings(a, b, roll < 25);
        done += a.size() + b.size() + 1;
      end
    end
  endtask

  // Long strings: full-size sweep and overflowing loads.
  task automatic send_long(input int n1, input int n2, input bit alike);
    logic [7:0] a[$];
    logic [7:0] b[$];
    int j;
    repeat (n1) a = {a, 8'($urandom)};
    for (j = 0; j < n2; j++) b = {b, ((alike && j < n1) ? a[j] : 8'($urandom))};
    if (alike && n2 > 10) begin
      b[3] = ~b[3];
      b.delete(7);
    end
    send_strings(a, b, 1'b0);
  endtask

  // Hold the output for a long stretch while compares pile up behind it.
  task automatic stall_output_long();
    logic [7:0] a[$];
    logic [7:0] b[$];
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    wait_drained();
    output_hold = 3000;
    repeat (4) begin
      a.delete();
      b.delete();
      repeat ($urandom_range(1, 5)) a = {a, pick_symbol(1'b1)};
      repeat ($urandom_range(1, 5)) b = {b, pick_symbol(1'b1)};
      send_strings(a, b, 1'b0);
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic run_directed();
    // two empty strings
    send_item(bed_pkg::OP_COMPARE, 8'h00);
    // second string empty, symbol extremes
    send_item(bed_pkg::OP_APPEND_FIRST, 8'h00);
    send_item(bed_pkg::OP_APPEND_FIRST, 8'hFF);
    send_item(bed_pkg::OP_COMPARE, 8'hFF);
    // first string empty
    send_item(bed_pkg::OP_APPEND_SECOND, 8'hFF);
    send_item(bed_pkg::OP_COMPARE, 8'h00);
    // equal strings
    send_item(bed_pkg::OP_APPEND_FIRST, 8'hA5);
    send_item(bed_pkg::OP_APPEND_SECOND, 8'hA5);
    send_item(bed_pkg::OP_APPEND_FIRST, 8'h5A);
    send_item(bed_pkg::OP_APPEND_SECOND, 8'h5A);
    send_item(bed_pkg::OP_COMPARE, 8'h00);
    // unused operation changes nothing
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    send_item(bed_pkg::OP_COMPARE, 8'h00);
    // zero limit: any difference is over
    write_limit(8'd0);
    send_item(bed_pkg::OP_APPEND_FIRST, 8'h01);
    send_item(bed_pkg::OP_APPEND_SECOND, 8'h02);
    send_item(bed_pkg::OP_COMPARE, 8'h00);
    send_item(bed_pkg::OP_APPEND_FIRST, 8'h07);
    send_item(bed_pkg::OP_APPEND_SECOND, 8'h07);
    send_item(bed_pkg::OP_COMPARE, 8'h00);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    write_limit(8'd255);
    run_phase(40, 0, 0);
    // both strings overflow; the kept symbols give a full-size sweep
    send_long(130, 130, 1'b1);

    write_limit(8'd128);
    run_phase(40, 54, 0);

    write_limit(8'd1);
    run_phase(40, 0, 54);

    write_limit(8'd3);
    stall_output_long();

    write_limit(8'($urandom_range(10)));
    run_phase(40, 28, 28);

    write_limit(8'd2);
    run_phase(40, 0, 0);

    // drain and let trailing loads settle
    in_valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);

    $display("Run covered %0d loads and %0d compares under limits 0 to 255, with idle and stall mixes.",
             dist_board.loads, dist_board.compares);
    $display("Results checked: %0d, over the limit: %0d, truncated: %0d.",
             dist_board.checked, dist_board.over_hits, dist_board.truncated_hits);
    if (dist_board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
